// ===== src/pixel_to_ground_plane_mapper_core_defines.svh =====
// Assertion macros shared by the checker. The enclosing scope provides clk and rst_n.
`ifndef PIXEL_TO_GROUND_PLANE_MAPPER_CORE_DEFINES_SVH
`define PIXEL_TO_GROUND_PLANE_MAPPER_CORE_DEFINES_SVH

// same-cycle implication
`define PGPM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgpm: same-cycle check failed");

// next-cycle implication
`define PGPM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgpm: next-cycle check failed");

`endif

// ===== src/pgpm_pkg.sv =====
`default_nettype none
package pgpm_pkg;

  localparam int PIXEL_BITS = 13;
  localparam int FRAC_BITS  = 16;
  localparam int TRIG_STEPS = 16;

  localparam int ATAN_LEN = 24;
  localparam int CORDIC_N = (TRIG_STEPS > ATAN_LEN) ? ATAN_LEN : TRIG_STEPS;

  // angles in 2^-16 degree
  localparam int ANG_W   = 27;
  localparam int DEG_ONE = 65536;
  localparam int DEG_90  = 90 * DEG_ONE;
  localparam int DEG_180 = 180 * DEG_ONE;
  localparam int DEG_360 = 360 * DEG_ONE;
  localparam int CORDIC_K = 652032874;

  // image dimension registers
  localparam int DIM_W = 13;

  // per-pixel datapath widths
  localparam int CNT_W  = (PIXEL_BITS > DIM_W) ? PIXEL_BITS : DIM_W;
  localparam int R_W    = CNT_W + 1;
  localparam int DX_W   = CNT_W + 2;
  localparam int P1_W   = 33 + R_W;
  localparam int HW_W   = P1_W + 1;
  localparam int P2_W   = HW_W + DX_W;
  localparam int DIV_NW = P2_W + 1;
  localparam int DIV_LAT = DIV_NW + 1;
  localparam int SAT_W  = (DIV_NW + 2 > 66) ? DIV_NW + 2 : 66;

  // input to result, in cycles
  localparam int PIPE_LAT = 7 + 2 * DIV_LAT;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2147483647);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-2147483647 - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPRESSION,
    REG_VFOV,
    REG_HFOV,
    REG_HEIGHT,
    REG_YAW,
    REG_ROWS,
    REG_COLUMNS
  } cfg_reg_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic signed [31:0] ground_x;
    logic signed [31:0] ground_y;
    logic               beyond_horizon;
  } gnd_out_t;

  // frame-constant terms derived from the configuration
  typedef struct packed {
    logic               beyond;
    logic signed [31:0] dist_near;
    logic signed [31:0] dist_far;
    logic signed [31:0] half_near;
    logic signed [31:0] half_far;
    logic signed [31:0] yaw_cos;
    logic signed [31:0] yaw_sin;
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
  } geom_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input logic [4:0] idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      5'd0:  a = 27'sd2949120;
      5'd1:  a = 27'sd1740967;
      5'd2:  a = 27'sd919879;
      5'd3:  a = 27'sd466945;
      5'd4:  a = 27'sd234379;
      5'd5:  a = 27'sd117304;
      5'd6:  a = 27'sd58666;
      5'd7:  a = 27'sd29335;
      5'd8:  a = 27'sd14668;
      5'd9:  a = 27'sd7334;
      5'd10: a = 27'sd3667;
      5'd11: a = 27'sd1833;
      5'd12: a = 27'sd917;
      5'd13: a = 27'sd458;
      5'd14: a = 27'sd229;
      5'd15: a = 27'sd115;
      5'd16: a = 27'sd57;
      5'd17: a = 27'sd29;
      5'd18: a = 27'sd14;
      5'd19: a = 27'sd7;
      5'd20: a = 27'sd4;
      5'd21: a = 27'sd2;
      5'd22: a = 27'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/pgpm_setup.sv =====
`default_nettype none
// Configuration registers plus a sequencer that derives the frame-constant
// terms with one shared CORDIC, one multiplier and a bit-serial divider.
module pgpm_setup (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_valid,
  input  wire [pgpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [pgpm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              busy,
  output pgpm_pkg::geom_t                   geom
);

  localparam int AW = pgpm_pkg::ANG_W;
  localparam int DWORK = 64;
  localparam int SH = pgpm_pkg::FRAC_BITS - 8;
  localparam logic signed [AW-1:0] A_90  = AW'(pgpm_pkg::DEG_90);
  localparam logic signed [AW-1:0] A_180 = AW'(pgpm_pkg::DEG_180);
  localparam logic signed [AW-1:0] A_360 = AW'(pgpm_pkg::DEG_360);
  localparam logic signed [32:0]   K_33  = 33'(pgpm_pkg::CORDIC_K);

  typedef enum logic [2:0] {
    S_IDLE, S_ANGLE, S_REDUCE, S_ROTATE, S_TRIG, S_MUL, S_PREP, S_DIV
  } state_t;
  typedef enum logic [2:0] {
    JOB_NEAR, JOB_FAR, JOB_HFOV, JOB_HNEAR, JOB_HFAR, JOB_YAW
  } job_t;

  state_t state_r;
  job_t   job_r;
  logic   fin_r;

  logic [14:0]        dep_r;
  logic [15:0]        vfov_r, hfov_r, height_r;
  logic signed [17:0] yaw_r;
  logic [pgpm_pkg::DIM_W-1:0] rows_r, cols_r;

  logic signed [AW-1:0] z_r;
  logic                 flip_r;
  logic signed [32:0]   crd_x_r, crd_y_r;
  logic [4:0]           step_r;

  logic signed [31:0] cos_r, sin_r, hcos_r, hsin_r, ycos_r, ysin_r;
  logic signed [31:0] dist_near_r, dist_far_r, half_near_r, half_far_r;

  logic signed [63:0] prod_r;
  logic signed [31:0] den_r;
  logic [DWORK-1:0]   work_r;
  logic [31:0]        rem_r, dabs_r;
  logic [5:0]         cnt_r;
  logic               qneg_r, nneg_r, nzero_r, dzero_r;

  logic signed [AW-1:0] dep_s, vfov_s, near_a, far_a, hfov_a, yaw_a;
  logic                 beyond;
  logic signed [AW-1:0] zf;
  logic signed [32:0]   sh_x, sh_y;
  logic signed [31:0]   mul_a, mul_b, mul_den;
  logic signed [63:0]   num_s;
  logic [32:0]          trial;
  logic                 take;
  logic signed [pgpm_pkg::SAT_W-1:0] qmag;
  logic signed [31:0]   quo;

  always_comb begin
    dep_s  = $signed(AW'(dep_r));
    vfov_s = $signed(AW'(vfov_r));
    near_a = ((dep_s <<< 1) + vfov_s) <<< 7;
    far_a  = ((dep_s <<< 1) - vfov_s) <<< 7;
    beyond = (far_a <= 0);
    hfov_a = $signed(AW'(hfov_r)) <<< 7;
    yaw_a  = AW'(yaw_r) <<< 8;

    zf = (z_r > A_180) ? z_r - A_360 : z_r;
    sh_x = crd_x_r >>> step_r;
    sh_y = crd_y_r >>> step_r;

    case (job_r)
      JOB_NEAR, JOB_FAR: begin
        mul_a = $signed({16'b0, height_r});
        mul_b = sin_r;
        mul_den = cos_r;
      end
      JOB_HNEAR: begin
        mul_a = dist_near_r;
        mul_b = hsin_r;
        mul_den = hcos_r;
      end
      default: begin
        mul_a = dist_far_r;
        mul_b = hsin_r;
        mul_den = hcos_r;
      end
    endcase

    num_s = (job_r == JOB_NEAR || job_r == JOB_FAR) ? (prod_r <<< SH) : prod_r;

    trial = {rem_r, work_r[DWORK-1]};
    take  = (trial >= {1'b0, dabs_r});

    qmag = $signed(pgpm_pkg::SAT_W'(work_r));
    if (dzero_r) begin
      quo = nzero_r ? 32'sd0 : (nneg_r ? 32'sh80000000 : 32'sh7fffffff);
    end else begin
      quo = pgpm_pkg::sat32(qneg_r ? -qmag : qmag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dep_r    <= 15'd9472;
      vfov_r   <= 16'd10240;
      hfov_r   <= 16'd15360;
      height_r <= 16'd768;
      yaw_r    <= 18'sd2560;
      rows_r   <= 13'd1080;
      cols_r   <= 13'd1920;
      state_r  <= S_ANGLE;
      job_r    <= JOB_NEAR;
      fin_r    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pgpm_pkg::REG_DEPRESSION: dep_r    <= cfg_data[14:0];
        pgpm_pkg::REG_VFOV:       vfov_r   <= cfg_data[15:0];
        pgpm_pkg::REG_HFOV:       hfov_r   <= cfg_data[15:0];
        pgpm_pkg::REG_HEIGHT:     height_r <= cfg_data[15:0];
        pgpm_pkg::REG_YAW:        yaw_r    <= $signed(cfg_data[17:0]);
        pgpm_pkg::REG_ROWS:       rows_r   <= cfg_data[12:0];
        pgpm_pkg::REG_COLUMNS:    cols_r   <= cfg_data[12:0];
        default: ;
      endcase
      // any write reruns the derivation
      state_r <= S_ANGLE;
      job_r   <= JOB_NEAR;
      fin_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: ;
        S_ANGLE: begin
          unique case (job_r)
            JOB_NEAR: begin
              z_r <= A_90 - near_a;
              state_r <= S_REDUCE;
            end
            JOB_FAR: begin
              if (beyond) begin
                dist_far_r <= 32'sh7fffffff;
                job_r <= JOB_HFOV;
              end else begin
                z_r <= A_90 - far_a;
                state_r <= S_REDUCE;
              end
            end
            JOB_HFOV: begin
              z_r <= hfov_a;
              state_r <= S_REDUCE;
            end
            JOB_YAW: begin
              z_r <= yaw_a;
              state_r <= S_REDUCE;
            end
            default: state_r <= S_MUL;
          endcase
        end
        S_REDUCE: begin
          if (z_r >= A_360) begin
            z_r <= z_r - A_360;
          end else if (z_r < 0) begin
            z_r <= z_r + A_360;
          end else begin
            if (zf > A_90) begin
              z_r <= zf - A_180;
              flip_r <= 1'b1;
            end else if (zf < -A_90) begin
              z_r <= zf + A_180;
              flip_r <= 1'b1;
            end else begin
              z_r <= zf;
              flip_r <= 1'b0;
            end
            crd_x_r <= K_33;
            crd_y_r <= '0;
            step_r  <= '0;
            state_r <= S_ROTATE;
          end
        end
        S_ROTATE: begin
          if (!z_r[AW-1]) begin
            crd_x_r <= crd_x_r - sh_y;
            crd_y_r <= crd_y_r + sh_x;
            z_r <= z_r - pgpm_pkg::atan_step(step_r);
          end else begin
            crd_x_r <= crd_x_r + sh_y;
            crd_y_r <= crd_y_r - sh_x;
            z_r <= z_r + pgpm_pkg::atan_step(step_r);
          end
          step_r <= step_r + 5'd1;
          if (step_r == 5'(pgpm_pkg::CORDIC_N - 1)) begin
            state_r <= S_TRIG;
          end
        end
        S_TRIG: begin
          unique case (job_r)
            JOB_NEAR, JOB_FAR: begin
              cos_r <= 32'(flip_r ? -crd_x_r : crd_x_r);
              sin_r <= 32'(flip_r ? -crd_y_r : crd_y_r);
              state_r <= S_MUL;
            end
            JOB_HFOV: begin
              hcos_r <= 32'(flip_r ? -crd_x_r : crd_x_r);
              hsin_r <= 32'(flip_r ? -crd_y_r : crd_y_r);
              job_r <= JOB_HNEAR;
              state_r <= S_MUL;
            end
            default: begin
              ycos_r <= 32'(flip_r ? -crd_x_r : crd_x_r);
              ysin_r <= 32'(flip_r ? -crd_y_r : crd_y_r);
              state_r <= S_IDLE;
            end
          endcase
        end
        S_MUL: begin
          prod_r <= 64'(mul_a) * 64'(mul_b);
          den_r  <= mul_den;
          state_r <= S_PREP;
        end
        S_PREP: begin
          work_r  <= num_s[63] ? DWORK'(-num_s) : DWORK'(num_s);
          rem_r   <= '0;
          dabs_r  <= den_r[31] ? 32'(-den_r) : 32'(den_r);
          qneg_r  <= num_s[63] ^ den_r[31];
          nneg_r  <= num_s[63];
          nzero_r <= (num_s == 0);
          dzero_r <= (den_r == 0);
          cnt_r   <= '0;
          fin_r   <= 1'b0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!fin_r) begin
            rem_r  <= take ? 32'(trial - {1'b0, dabs_r}) : trial[31:0];
            work_r <= {work_r[DWORK-2:0], take};
            cnt_r  <= cnt_r + 6'd1;
            if (cnt_r == 6'(DWORK - 1)) begin
              fin_r <= 1'b1;
            end
          end else begin
            fin_r <= 1'b0;
            unique case (job_r)
              JOB_NEAR: begin
                dist_near_r <= quo;
                job_r <= JOB_FAR;
                state_r <= S_ANGLE;
              end
              JOB_FAR: begin
                dist_far_r <= quo;
                job_r <= JOB_HFOV;
                state_r <= S_ANGLE;
              end
              JOB_HNEAR: begin
                half_near_r <= quo;
                job_r <= JOB_HFAR;
                state_r <= S_MUL;
              end
              default: begin
                half_far_r <= quo;
                job_r <= JOB_YAW;
                state_r <= S_ANGLE;
              end
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    geom.beyond    = beyond;
    geom.dist_near = dist_near_r;
    geom.dist_far  = dist_far_r;
    geom.half_near = half_near_r;
    geom.half_far  = half_far_r;
    geom.yaw_cos   = ycos_r;
    geom.yaw_sin   = ysin_r;
    geom.rows      = (rows_r == '0) ? pgpm_pkg::DIM_W'(1) : rows_r;
    geom.cols      = (cols_r == '0) ? pgpm_pkg::DIM_W'(1) : cols_r;
  end

endmodule
`default_nettype wire

// ===== src/pgpm_div_pipe.sv =====
`default_nettype none
// Signed numerator over a positive divisor, truncating toward zero.
// One quotient bit per stage, result registered at the end.
module pgpm_div_pipe (
  input  wire                                     clk,
  input  wire signed [pgpm_pkg::DIV_NW-1:0]       num,
  input  wire        [pgpm_pkg::DIM_W-1:0]        den,
  output logic signed [pgpm_pkg::DIV_NW-1:0]      quo
);

  localparam int NW = pgpm_pkg::DIV_NW;
  localparam int DW = pgpm_pkg::DIM_W;

  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] work_r [NW];
  logic [DW-1:0] den_r  [NW];
  logic          neg_r  [NW];

  logic [NW-1:0] mag_in;
  logic signed [NW-1:0] quo_r;

  assign mag_in = num[NW-1] ? NW'(-num) : NW'(num);

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [NW-1:0] work_in;
    logic          neg_in;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = mag_in;
      assign den_in  = den;
      assign neg_in  = num[NW-1];
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign work_in = work_r[k-1];
      assign den_in  = den_r[k-1];
      assign neg_in  = neg_r[k-1];
    end

    assign trial = {rem_in, work_in[NW-1]};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      rem_r[k]  <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      work_r[k] <= {work_in[NW-2:0], take};
      den_r[k]  <= den_in;
      neg_r[k]  <= neg_in;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= neg_r[NW-1] ? -$signed(work_r[NW-1]) : $signed(work_r[NW-1]);
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

// ===== src/pgpm_map_pipe.sv =====
`default_nettype none
// Per-pixel datapath: trapezoid interpolation, two divides by the image
// size and the yaw rotation. One pixel per cycle, no back-pressure.
module pgpm_map_pipe (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  input  wire pgpm_pkg::pix_in_t     in_pix,
  input  wire pgpm_pkg::geom_t       geom,
  output logic                       out_valid,
  output pgpm_pkg::gnd_out_t         out_data
);

  localparam int R_W   = pgpm_pkg::R_W;
  localparam int DX_W  = pgpm_pkg::DX_W;
  localparam int P1_W  = pgpm_pkg::P1_W;
  localparam int HW_W  = pgpm_pkg::HW_W;
  localparam int P2_W  = pgpm_pkg::P2_W;
  localparam int NW    = pgpm_pkg::DIV_NW;
  localparam int LAT   = pgpm_pkg::DIV_LAT;
  localparam int SW    = pgpm_pkg::SAT_W;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< 29;

  // stage 1: row offset from the bottom, signed column span
  logic                   v1_r;
  logic signed [R_W-1:0]  r1_r;
  logic signed [DX_W-1:0] dx1_r;
  // stage 2: interpolation products
  logic                   v2_r;
  logic signed [P1_W-1:0] ph2_r, py2_r;
  logic signed [DX_W-1:0] dx2_r;
  // across the row divide
  logic                   va_r  [LAT];
  logic signed [DX_W-1:0] dxa_r [LAT];
  logic signed [NW-1:0]   qh, qy;
  // stage 3
  logic                   v3_r;
  logic signed [HW_W-1:0] hw3_r;
  logic signed [31:0]     y3_r;
  logic signed [DX_W-1:0] dx3_r;
  // stage 4
  logic                   v4_r;
  logic signed [P2_W-1:0] px4_r;
  logic signed [31:0]     y4_r;
  // across the column divide
  logic                   vb_r [LAT];
  logic signed [31:0]     yb_r [LAT];
  logic signed [NW-1:0]   qx;
  // stage 5..7
  logic                   v5_r, v6_r, v7_r;
  logic signed [31:0]     x5_r, y5_r;
  logic signed [63:0]     xc6_r, ys6_r, xs6_r, yc6_r;
  logic signed [31:0]     gx7_r, gy7_r;
  logic                   bh7_r;

  logic signed [32:0] dh, dy;
  logic signed [SW-1:0] sum_x, sum_y;

  always_comb begin
    dh = 33'(geom.half_far) - 33'(geom.half_near);
    dy = 33'(geom.dist_far) - 33'(geom.dist_near);
    sum_x = (SW'(xc6_r) - SW'(ys6_r) + RND) >>> 30;
    sum_y = (SW'(xs6_r) + SW'(yc6_r) + RND) >>> 30;
  end

  pgpm_div_pipe u_div_h (
    .clk (clk),
    .num (NW'(ph2_r)),
    .den (geom.rows),
    .quo (qh)
  );

  pgpm_div_pipe u_div_y (
    .clk (clk),
    .num (NW'(py2_r)),
    .den (geom.rows),
    .quo (qy)
  );

  pgpm_div_pipe u_div_x (
    .clk (clk),
    .num (NW'(px4_r)),
    .den (geom.cols),
    .quo (qx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      for (int k = 0; k < LAT; k++) begin
        va_r[k] <= 1'b0;
        vb_r[k] <= 1'b0;
      end
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      va_r[0] <= v2_r;
      vb_r[0] <= v4_r;
      for (int k = 1; k < LAT; k++) begin
        va_r[k] <= va_r[k-1];
        vb_r[k] <= vb_r[k-1];
      end
      v3_r <= va_r[LAT-1];
      v4_r <= v3_r;
      v5_r <= vb_r[LAT-1];
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    r1_r  <= $signed(R_W'(geom.rows) - R_W'(in_pix.pixel_y));
    dx1_r <= $signed(DX_W'({in_pix.pixel_x, 1'b0}) - DX_W'(geom.cols));

    ph2_r <= P1_W'(dh) * P1_W'(r1_r);
    py2_r <= P1_W'(dy) * P1_W'(r1_r);
    dx2_r <= dx1_r;

    dxa_r[0] <= dx2_r;
    yb_r[0]  <= y4_r;
    for (int k = 1; k < LAT; k++) begin
      dxa_r[k] <= dxa_r[k-1];
      yb_r[k]  <= yb_r[k-1];
    end

    hw3_r <= HW_W'(geom.half_near) + HW_W'(qh);
    y3_r  <= pgpm_pkg::sat32(SW'(geom.dist_near) + SW'(qy));
    dx3_r <= dxa_r[LAT-1];

    px4_r <= P2_W'(hw3_r) * P2_W'(dx3_r);
    y4_r  <= y3_r;

    x5_r <= pgpm_pkg::sat32(SW'(qx));
    y5_r <= yb_r[LAT-1];

    xc6_r <= 64'(x5_r) * 64'(geom.yaw_cos);
    ys6_r <= 64'(y5_r) * 64'(geom.yaw_sin);
    xs6_r <= 64'(x5_r) * 64'(geom.yaw_sin);
    yc6_r <= 64'(y5_r) * 64'(geom.yaw_cos);

    gx7_r <= pgpm_pkg::sat32(sum_x);
    gy7_r <= pgpm_pkg::sat32(sum_y);
    bh7_r <= geom.beyond;
  end

  assign out_valid = v7_r;
  always_comb begin
    out_data.ground_x       = gx7_r;
    out_data.ground_y       = gy7_r;
    out_data.beyond_horizon = bh7_r;
  end

endmodule
`default_nettype wire

// ===== src/pixel_to_ground_plane_mapper_core.sv =====
// Maps pixels to ground-plane metres (Q16.16) for a tilted, yawed camera. A
// pixel is taken at each clock edge where start is high and busy is low, so a
// new pixel may enter every cycle. out_valid marks each result on out_data for
// exactly one cycle, in input order. The receiver cannot stall. Most of the
// pipeline depth comes from the two one-bit-per-stage divides by image rows and
// image columns (64 quotient stages plus an output register each); seven
// more stages carry the row/column terms, interpolation products and the yaw
// rotation. After reset and after every configuration write, busy stays high
// while a shared CORDIC and a bit-serial divider recompute the near/far
// distances, edge half-widths and yaw sine/cosine; the far distance is not
// computed when the far edge is at or above the horizon. cfg_ready is always
// high; write configuration only when no results are outstanding.
`default_nettype none
module pixel_to_ground_plane_mapper_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire pgpm_pkg::pix_in_t           in_data,
  output logic                             out_valid,
  output pgpm_pkg::gnd_out_t               out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [pgpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [pgpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pgpm_pkg::geom_t geom;
  logic            in_xfer;

  assign cfg_ready = 1'b1;
  assign in_xfer   = start & ~busy;

  pgpm_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .geom      (geom)
  );

  pgpm_map_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_xfer),
    .in_pix    (in_data),
    .geom      (geom),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== src/pgpm_checker.sv =====
`default_nettype none
`include "pixel_to_ground_plane_mapper_core_defines.svh"
module pgpm_checker (
  input wire clk,
  input wire rst_n,
  input wire start,
  input wire busy,
  input wire cfg_valid,
  input wire cfg_ready,
  input wire out_valid
);

  // a config transfer always triggers a recompute
  `PGPM_ASSERT_NXT(a_cfg_busy, cfg_valid && cfg_ready, busy)
  // every result traces back to a pixel transfer a fixed latency earlier
  `PGPM_ASSERT_IMP(a_out_src, out_valid, $past(start && !busy, pgpm_pkg::PIPE_LAT))
  // recompute cannot finish in the cycle after a config transfer
  `PGPM_ASSERT_IMP(a_busy_fall, $fell(busy), !$past(cfg_valid && cfg_ready))

endmodule

bind pixel_to_ground_plane_mapper_core pgpm_checker u_pgpm_checker (.*);
`default_nettype wire

// ===== sim/pixel_to_ground_plane_mapper_core_tb.sv =====
`default_nettype none
module pixel_to_ground_plane_mapper_core_tb;

  localparam int PB = pgpm_pkg::PIXEL_BITS;
  localparam int IDX_W = pgpm_pkg::CFG_IDX_W;
  localparam int DATA_W = pgpm_pkg::CFG_DATA_W;
  localparam longint ONE_DEG = 65536;
  localparam longint Q_90 = 90 * ONE_DEG;
  localparam longint Q_180 = 180 * ONE_DEG;
  localparam longint Q_360 = 360 * ONE_DEG;
  localparam longint GAIN_START = 652032874;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint NEG_MAX = -64'sd2147483648;
  localparam logic [IDX_W-1:0] REG_UNMAPPED = IDX_W'(7);
  localparam int IDLE_LIMIT = 6000;

  class ground_scoreboard;
    longint dep, vfov, hfov, height, yaw, rows, cols;
    pgpm_pkg::gnd_out_t expected_q[$];
    int errors;
    int results;
    int beyond_seen;
    longint arc_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                            14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};

    function void load_defaults();
      dep = 9472; vfov = 10240; hfov = 15360; height = 768;
      yaw = 2560; rows = 1080; cols = 1920;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
      case (idx)
        pgpm_pkg::REG_DEPRESSION: dep = longint'(d[14:0]);
        pgpm_pkg::REG_VFOV:       vfov = longint'(d[15:0]);
        pgpm_pkg::REG_HFOV:       hfov = longint'(d[15:0]);
        pgpm_pkg::REG_HEIGHT:     height = longint'(d[15:0]);
        pgpm_pkg::REG_YAW:        yaw = longint'($signed(d[17:0]));
        pgpm_pkg::REG_ROWS:       rows = longint'(d[12:0]);
        pgpm_pkg::REG_COLUMNS:    cols = longint'(d[12:0]);
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < NEG_MAX) return NEG_MAX;
      return v;
    endfunction

    function longint clip_div(longint num, longint den);
      if (den == 0) begin
        if (num == 0) return 0;
        return (num > 0) ? POS_MAX : NEG_MAX;
      end
      return clip32(num / den);
    endfunction

    // rotation-mode CORDIC, angle in 2^-16 degree, results Q2.30
    function void rotate_unit(longint ang, output longint c, output longint s);
      longint x, y, nx;
      bit flip;
      x = GAIN_START; y = 0; flip = 0;
      ang = ang % Q_360;
      if (ang < 0) ang += Q_360;
      if (ang > Q_180) ang -= Q_360;
      if (ang > Q_90) begin
        ang -= Q_180; flip = 1;
      end else if (ang < -Q_90) begin
        ang += Q_180; flip = 1;
      end
      for (int i = 0; i < pgpm_pkg::CORDIC_N; i++) begin
        if (ang >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); ang -= arc_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); ang += arc_tab[i];
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint ground_range(longint ang);
      longint c, s;
      rotate_unit(Q_90 - ang, c, s);
      return clip_div(height * s * 256, c);
    endfunction

    function pgpm_pkg::gnd_out_t map_pixel(pgpm_pkg::pix_in_t p);
      pgpm_pkg::gnd_out_t g;
      longint px, py, nr, nc, near_a, far_a, dn, df, ch, sh, hn, hf, r, hw, x, y, cy, sy;
      bit over;
      px = longint'(p.pixel_x); py = longint'(p.pixel_y);
      nr = rows ? rows : 1;
      nc = cols ? cols : 1;
      near_a = (dep * 2 + vfov) * 128;
      far_a = (dep * 2 - vfov) * 128;
      over = far_a <= 0;
      dn = ground_range(near_a);
      df = over ? POS_MAX : ground_range(far_a);
      rotate_unit(hfov * 128, ch, sh);
      hn = clip_div(dn * sh, ch);
      hf = clip_div(df * sh, ch);
      r = nr - py;
      hw = hn + ((hf - hn) * r) / nr;
      x = clip32((hw * (2 * px - nc)) / nc);
      y = clip32(dn + ((df - dn) * r) / nr);
      rotate_unit(yaw * 256, cy, sy);
      g.ground_x = 32'(clip32((x * cy - y * sy + (64'sd1 <<< 29)) >>> 30));
      g.ground_y = 32'(clip32((x * sy + y * cy + (64'sd1 <<< 29)) >>> 30));
      g.beyond_horizon = over;
      return g;
    endfunction

    function void note_pixel(pgpm_pkg::pix_in_t p);
      expected_q.push_back(map_pixel(p));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check_result(pgpm_pkg::gnd_out_t got);
      pgpm_pkg::gnd_out_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", longint'(1), longint'(0));
        return;
      end
      want = expected_q.pop_front();
      results++;
      if (got.beyond_horizon) beyond_seen++;
      if (got.ground_x !== want.ground_x)
        report("ground_x", longint'(got.ground_x), longint'(want.ground_x));
      if (got.ground_y !== want.ground_y)
        report("ground_y", longint'(got.ground_y), longint'(want.ground_y));
      if (got.beyond_horizon !== want.beyond_horizon)
        report("beyond_horizon", longint'(got.beyond_horizon),
               longint'(want.beyond_horizon));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  pgpm_pkg::pix_in_t in_data = '0;
  logic out_valid;
  pgpm_pkg::gnd_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  ground_scoreboard sb = new();
  int idle_cycles = 0;
  int n_pixels = 0;
  int n_writes = 0;
  bit no_gaps = 0;

  pixel_to_ground_plane_mapper_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function int pick_gap();
    int k;
    if (no_gaps) return 0;
    k = $urandom_range(0, 99);
    if (k < 65) return 0;
    if (k < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // coordinates are cut to the field width
  task automatic send_pixel(int px, int py);
    int gap;
    pgpm_pkg::pix_in_t p;
    p.pixel_x = PB'(px);
    p.pixel_y = PB'(py);
    in_data <= p;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_pixel(p);
    n_pixels++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
    drain();
    repeat (4) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, d);
    n_writes++;
  endtask

  task automatic write_geometry(int dep, int vf, int hf, int h, int yw, int nr, int nc);
    write_reg(pgpm_pkg::REG_DEPRESSION, DATA_W'(dep));
    write_reg(pgpm_pkg::REG_VFOV, DATA_W'(vf));
    write_reg(pgpm_pkg::REG_HFOV, DATA_W'(hf));
    write_reg(pgpm_pkg::REG_HEIGHT, DATA_W'(h));
    write_reg(pgpm_pkg::REG_YAW, DATA_W'(yw));
    write_reg(pgpm_pkg::REG_ROWS, DATA_W'(nr));
    write_reg(pgpm_pkg::REG_COLUMNS, DATA_W'(nc));
  endtask

  // mostly pixels inside the image, some anywhere in the 13-bit field
  task automatic random_pixels(int count);
    int px, py;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        px = $urandom_range(0, int'((sb.cols > 0) ? sb.cols : 1));
        py = $urandom_range(0, int'((sb.rows > 0) ? sb.rows : 1));
      end else begin
        px = $urandom;
        py = $urandom;
      end
      send_pixel(px, py);
      if (i == count / 2 && $urandom_range(0, 1)) drain();
    end
  endtask

  task automatic random_geometry();
    int k;
    k = $urandom_range(0, 9);
    write_geometry(
      (k == 0) ? $urandom_range(0, 32767) : $urandom_range(256, 23040),
      (k == 1) ? $urandom_range(0, 65535) : $urandom_range(0, 46080),
      (k == 2) ? $urandom_range(0, 65535) : $urandom_range(0, 46080),
      $urandom_range(0, 65535),
      (k == 3) ? $urandom_range(0, 262143) - 131072 : $urandom_range(0, 184320) - 92160,
      (k == 4) ? $urandom_range(0, 8191) : $urandom_range(1, 4096),
      (k == 5) ? $urandom_range(0, 8191) : $urandom_range(1, 4096));
  endtask

  initial begin
    sb.load_defaults();
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // defaults: corners, center and field extremes
    no_gaps = 1;
    send_pixel(0, 0);
    send_pixel(1919, 1079);
    send_pixel(960, 540);
    send_pixel(1920, 1080);
    send_pixel(8191, 8191);
    send_pixel(0, 8191);
    send_pixel(8191, 0);
    no_gaps = 0;

    // far edge above the horizon, zero-size image, zero height, zero hfov
    write_geometry(1000, 10240, 0, 0, -92160, 0, 0);
    send_pixel(0, 0);
    send_pixel(5, 7);
    send_pixel(8191, 8191);
    // cosine zero in half-width tangent, maximum height and wrapped yaw
    write_geometry(23040, 46080, 46080, 65535, 92160, 4096, 4096);
    send_pixel(0, 4096);
    send_pixel(4096, 0);
    send_pixel(2048, 2048);
    // raw register extremes, angles wrapping past 360
    write_geometry(32767, 65535, 65535, 1, -131072, 8191, 8191);
    send_pixel(0, 0);
    send_pixel(8191, 8191);
    write_reg(REG_UNMAPPED, 18'h3ffff);
    write_geometry(11520, 0, 23040, 256, 131071, 1, 1);
    send_pixel(0, 0);
    send_pixel(1, 1);
    send_pixel(2, 3);

    for (int ph = 0; ph < 8; ph++) begin
      random_geometry();
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, DATA_W'($urandom));
      no_gaps = (ph % 3 == 1);
      random_pixels(110);
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.pending() != 0)
      sb.report("results still owed", longint'(sb.pending()), longint'(0));
    $display("covered %0d pixels, %0d register writes, %0d results (%0d beyond horizon)",
             n_pixels, n_writes, sb.results, sb.beyond_seen);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
